// File: sv/dvrt_pkg.sv
// Shared types, codes and sizes for the distance-vector route table.
// No dependencies; imported by dvrt_ctrl, dvrt_datapath and the top level.
package dvrt_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DVRT_TABLE_ENTRIES  = 64;
    localparam int DVRT_NEIGHBOR_SLOTS = 4;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int METRIC_W  = 5;
    localparam int AGE_W     = 8;
    localparam int OWNER_W   = 2;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NCOUNT_W  = 3;

    localparam logic [METRIC_W-1:0] METRIC_INFINITY = 5'd16;
    localparam logic [AGE_W-1:0]    AGE_MAX         = 8'hFF;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 2'd3;

    // Configuration register indexes (neighbor addresses are 0..3)
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_COUNT = 3'd4;

    // One stored route
    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [ADDR_W-1:0]   network;
        logic [ADDR_W-1:0]   netmask;
        logic [METRIC_W-1:0] hops;
        logic [AGE_W-1:0]    age;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture item, clear scan state
        logic scan_run;     // walk the table
        logic append;       // place a new route at the fill point
        logic result_load;  // move result into the output register
    } dp_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic need_append;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: sv/dvrt_ctrl.sv
// Sequencing state machine for the route table: accept, scan, append, result.
// Depends on dvrt_pkg; drives dvrt_datapath through dp_ctrl_t.
module dvrt_ctrl import dvrt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                ctrl.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = stat.need_append ? S_APPEND : S_RESULT;
                end
            end
            S_APPEND: begin
                ctrl.append = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (!stat.out_busy) begin
                    ctrl.result_load = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// File: sv/dvrt_datapath.sv
// Route table datapath: neighbor registers, entry memory, scan pipeline, result register.
// Depends on dvrt_pkg; sequenced by dvrt_ctrl.
module dvrt_datapath import dvrt_pkg::*; #(
    parameter int TABLE_ENTRIES  = DVRT_TABLE_ENTRIES,
    parameter int NEIGHBOR_SLOTS = DVRT_NEIGHBOR_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    // item fields
    input  logic [CMD_W-1:0]      s_command,
    input  logic [ADDR_W-1:0]     s_source_addr,
    input  logic [ADDR_W-1:0]     s_route_dst,
    input  logic [ADDR_W-1:0]     s_route_mask,
    input  logic [METRIC_W-1:0]   s_route_metric,
    input  logic [ADDR_W-1:0]     s_lookup_addr,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [OWNER_W-1:0]    m_neighbor_index,
    output logic                  m_was_existing,
    // control
    input  dp_ctrl_t              ctrl,
    output dp_stat_t              stat
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Neighbor configuration
    logic [ADDR_W-1:0]   nbr_addr_reg [NEIGHBOR_SLOTS];
    logic [NCOUNT_W-1:0] nbr_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NEIGHBOR_SLOTS; n++) begin
                nbr_addr_reg[n] <= '0;
            end
            nbr_count_reg <= '0;
        end else if (cfg_valid) begin
            for (int n = 0; n < NEIGHBOR_SLOTS; n++) begin
                if (cfg_index == CFG_IDX_W'(n)) begin
                    nbr_addr_reg[n] <= cfg_data;
                end
            end
            if (cfg_index == CFG_NBR_COUNT) begin
                nbr_count_reg <= cfg_data[NCOUNT_W-1:0];
            end
        end
    end

    // Captured item
    logic [CMD_W-1:0]    cmd_reg;
    logic [ADDR_W-1:0]   src_reg, dst_reg, msk_reg, lk_addr_reg;
    logic [METRIC_W-1:0] met_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg     <= s_command;
            src_reg     <= s_source_addr;
            dst_reg     <= s_route_dst;
            msk_reg     <= s_route_mask;
            met_reg     <= (s_route_metric > METRIC_INFINITY) ? METRIC_INFINITY
                                                              : s_route_metric;
            lk_addr_reg <= s_lookup_addr;
        end
    end

    // Sender lookup: lowest matching slot among those in use
    logic [NCOUNT_W-1:0] slots_used;
    logic                known;
    logic [OWNER_W-1:0]  owner;

    assign slots_used = (nbr_count_reg > NCOUNT_W'(NEIGHBOR_SLOTS))
                      ? NCOUNT_W'(NEIGHBOR_SLOTS) : nbr_count_reg;

    always_comb begin
        known = 1'b0;
        owner = '0;
        for (int n = NEIGHBOR_SLOTS - 1; n >= 0; n--) begin
            if ((NCOUNT_W'(n) < slots_used) && (nbr_addr_reg[n] == src_reg)) begin
                known = 1'b1;
                owner = OWNER_W'(n);
            end
        end
    end

    // Entry memory; valid entries always form the prefix below the fill count
    entry_t          tbl_mem [TABLE_ENTRIES];
    logic [CW-1:0]   fill_count_reg;
    logic            table_full;

    assign table_full = (fill_count_reg == CW'(TABLE_ENTRIES));

    // Scan pipeline: issue read, then process registered data
    logic [CW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          pend_reg;
    entry_t        rd_data_reg;
    logic          issue;

    assign issue = ctrl.scan_run && (rd_idx_reg < fill_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
        end else if (ctrl.load) begin
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
        end else if (ctrl.scan_run) begin
            pend_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_addr_reg <= rd_idx_reg[AW-1:0];
            rd_data_reg <= tbl_mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Per-entry checks on the data just read
    logic proc, hit_upd, hit_lk;

    assign proc    = ctrl.scan_run && pend_reg;
    assign hit_upd = known && (rd_data_reg.owner == owner)
                   && (rd_data_reg.network == dst_reg);
    assign hit_lk  = (rd_data_reg.network == (lk_addr_reg & rd_data_reg.netmask));

    // Write port selection
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = rd_data_reg;
        if (ctrl.append) begin
            wr_en           = !table_full;
            wr_addr         = fill_count_reg[AW-1:0];
            wr_data.owner   = owner;
            wr_data.network = dst_reg;
            wr_data.netmask = msk_reg;
            wr_data.hops    = met_reg;
            wr_data.age     = '0;
        end else if (proc) begin
            case (cmd_reg)
                CMD_UPDATE: begin
                    wr_en           = hit_upd;
                    wr_data.netmask = msk_reg;
                    wr_data.hops    = met_reg;
                    wr_data.age     = '0;
                end
                CMD_TICK: begin
                    wr_en = 1'b1;
                    if (rd_data_reg.age != AGE_MAX) begin
                        wr_data.age = rd_data_reg.age + 1'b1;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
        end else if (ctrl.append && !table_full) begin
            fill_count_reg <= fill_count_reg + 1'b1;
        end
    end

    // Scan accumulators
    logic               existed_reg, found_reg, full_err_reg;
    logic [OWNER_W-1:0] nidx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.load) begin
            existed_reg  <= 1'b0;
            found_reg    <= 1'b0;
            full_err_reg <= 1'b0;
            nidx_reg     <= '0;
        end else begin
            if (proc && (cmd_reg == CMD_UPDATE) && hit_upd) begin
                existed_reg <= 1'b1;
            end
            if (proc && (cmd_reg == CMD_LOOKUP) && hit_lk) begin
                found_reg <= 1'b1;
                if (!found_reg || (rd_data_reg.owner > nidx_reg)) begin
                    nidx_reg <= rd_data_reg.owner;
                end
            end
            if (ctrl.append && table_full) begin
                full_err_reg <= 1'b1;
            end
        end
    end

    // Result formation
    logic [STATUS_W-1:0] res_status;
    logic [OWNER_W-1:0]  res_nidx;
    logic                res_existed;

    always_comb begin
        res_status  = ST_OK;
        res_nidx    = '0;
        res_existed = 1'b0;
        case (cmd_reg)
            CMD_UPDATE: begin
                if (!known) begin
                    res_status = ST_UNKNOWN;
                end else if (existed_reg) begin
                    res_existed = 1'b1;
                end else if (full_err_reg) begin
                    res_status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (found_reg) begin
                    res_nidx = nidx_reg;
                end else begin
                    res_status = ST_NO_ROUTE;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // Output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [OWNER_W-1:0]  m_nidx_reg;
    logic                m_existed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.result_load) begin
            m_status_reg  <= res_status;
            m_nidx_reg    <= res_nidx;
            m_existed_reg <= res_existed;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_neighbor_index = m_nidx_reg;
    assign m_was_existing   = m_existed_reg;

    // Status to controller
    assign stat.scan_done   = ctrl.scan_run && !issue && !pend_reg;
    assign stat.need_append = (cmd_reg == CMD_UPDATE) && known && !existed_reg;
    assign stat.out_busy    = m_valid_reg && !m_ready;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_wb_in_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !ctrl.append) |-> (CW'(wr_addr) < fill_count_reg))
        else $error("scan write-back outside valid entries");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.append && !table_full) |=>
            (fill_count_reg == CW'($past(fill_count_reg) + 1'b1)))
        else $error("append did not advance fill count");

    a_append_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.append |-> ((cmd_reg == CMD_UPDATE) && known && !existed_reg))
        else $error("append without a new route from a known sender");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.result_load |=> m_valid_reg)
        else $error("result loaded but not presented");

endmodule

// File: sv/distance_vector_route_table.sv
// Distance-vector route table: top level joining controller and datapath.
// Depends on dvrt_pkg, dvrt_ctrl and dvrt_datapath.
//
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   neighbor addresses (index 0..3) and the neighbor count (index 4); cfg_ready
//   is always high. Write only while no item is in flight.
//   Input channel s_*: one command item (update, tick or lookup). Output channel
//   m_*: exactly one result item (status, neighbor_index, was_existing) per item.
//   Each item walks the filled part of the entry memory through its single read
//   port, one entry a cycle through a registered read, writing back in place.
//   An update that adds a route passes the append state before its result.
//   One item is worked on at a time.
//   The output register holds a finished result while a new item is accepted;
//   if the receiver stalls, the next result waits in the datapath until m_ready.
//   Reset (aresetn low, synchronous) empties the table at once through the fill
//   count, clears the neighbor registers and drops m_valid; no clearing pass.
module distance_vector_route_table import dvrt_pkg::*; #(
    parameter int TABLE_ENTRIES  = DVRT_TABLE_ENTRIES,
    parameter int NEIGHBOR_SLOTS = DVRT_NEIGHBOR_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [ADDR_W-1:0]    s_source_addr,
    input  logic [ADDR_W-1:0]    s_route_dst,
    input  logic [ADDR_W-1:0]    s_route_mask,
    input  logic [METRIC_W-1:0]  s_route_metric,
    input  logic [ADDR_W-1:0]    s_lookup_addr,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [OWNER_W-1:0]   m_neighbor_index,
    output logic                 m_was_existing
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    dvrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    dvrt_datapath #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_command        (s_command),
        .s_source_addr    (s_source_addr),
        .s_route_dst      (s_route_dst),
        .s_route_mask     (s_route_mask),
        .s_route_metric   (s_route_metric),
        .s_lookup_addr    (s_lookup_addr),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_neighbor_index (m_neighbor_index),
        .m_was_existing   (m_was_existing),
        .ctrl             (ctrl),
        .stat             (stat)
    );

endmodule
